// File: hdl/world_to_screen_projection_defines.svh
// Assertion macros shared by the projector RTL.
// No dependencies.
`ifndef WORLD_TO_SCREEN_PROJECTION_DEFINES_SVH
`define WORLD_TO_SCREEN_PROJECTION_DEFINES_SVH

// Implication checked every clock edge outside reset.
`define W2S_ASSERT_IMP(lbl, clk, rst_n, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
    else $error("assertion failed");

// Next-cycle implication checked outside reset.
`define W2S_ASSERT_NXT(lbl, clk, rst_n, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
    else $error("assertion failed");

`endif

// File: hdl/w2s_pkg.sv
// Types and constants of the world-to-screen projector.
// No dependencies.
`default_nettype none
package w2s_pkg;
  localparam int AccW = 48;
  localparam logic signed [31:0] OneQ16 = 32'sd65536;
  localparam logic [0:0] KindProject = 1'b0;
  localparam logic [0:0] KindLoad = 1'b1;
  localparam logic [0:0] MatView = 1'b0;
  localparam logic [0:0] MatProj = 1'b1;
  localparam logic [0:0] RegWidth = 1'b0;
  localparam logic [0:0] RegHeight = 1'b1;

  typedef struct packed {
    logic               kind;
    logic               matrix_select;
    logic [3:0]         element_index;
    logic signed [31:0] element_value;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
  } w2s_in_t;

  typedef struct packed {
    logic        on_screen;
    logic [28:0] screen_x;
    logic [28:0] screen_y;
    logic [16:0] depth;
  } w2s_out_t;

  typedef logic signed [AccW-1:0] vec4_t [4];

  function automatic logic signed [AccW-1:0] sat48(input logic signed [AccW+15:0] v);
    logic signed [AccW+15:0] mx;
    logic signed [AccW+15:0] mn;
    mx = {{17{1'b0}}, {(AccW-1){1'b1}}};
    mn = ~mx;
    if (v > mx) return mx[AccW-1:0];
    if (v < mn) return mn[AccW-1:0];
    return v[AccW-1:0];
  endfunction
endpackage
`default_nettype wire

// File: hdl/w2s_xform.sv
// One matrix-vector stage: registered partial products, rounded products, column sums.
// Depends on w2s_pkg.
`default_nettype none
module w2s_xform
  import w2s_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   en,
  input  wire logic                   v_in,
  input  wire logic signed [AccW-1:0] vin [4],
  input  wire logic signed [31:0]     mat [16],
  output logic                        v_out,
  output logic signed [AccW-1:0]      vout [4]
);
  // a = hi*2^16 + lo, so floor((a*m + 2^15) / 2^16) = hi*m + floor((lo*m + 2^15) / 2^16).
  logic signed [63:0]     ph_r [16];
  logic signed [63:0]     ph_nxt [16];
  logic signed [48:0]     pl_r [16];
  logic signed [48:0]     pl_nxt [16];
  logic signed [AccW-1:0] prod_r [16];
  logic signed [AccW-1:0] prod_nxt [16];
  logic signed [AccW-1:0] sum_nxt [4];
  logic                   va_r;
  logic                   vb_r;

  always_comb begin
    for (int i = 0; i < 16; i++) begin
      ph_nxt[i] = $signed(vin[i/4][AccW-1:16]) * mat[i];
      pl_nxt[i] = $signed({1'b0, vin[i/4][15:0]}) * mat[i];
    end
  end

  always_comb begin
    for (int i = 0; i < 16; i++) begin
      logic signed [AccW+15:0] rl;
      rl = (64'(pl_r[i]) + 64'sd32768) >>> 16;
      prod_nxt[i] = sat48(ph_r[i] + rl);
    end
  end

  always_comb begin
    for (int c = 0; c < 4; c++) begin
      logic signed [AccW+15:0] acc;
      acc = '0;
      for (int r = 0; r < 4; r++) acc = acc + (AccW+16)'(prod_r[r*4+c]);
      sum_nxt[c] = sat48(acc);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      vb_r <= 1'b0;
      v_out <= 1'b0;
    end else if (en) begin
      va_r <= v_in;
      vb_r <= va_r;
      v_out <= vb_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ph_r <= ph_nxt;
      pl_r <= pl_nxt;
      prod_r <= prod_nxt;
      vout <= sum_nxt;
    end
  end
endmodule
`default_nettype wire

// File: hdl/w2s_divider.sv
// Pipelined restoring divider: quotient of num/den, one bit per stage.
// Depends on w2s_pkg only for style consistency.
`default_nettype none
module w2s_divider
  import w2s_pkg::*;
#(
  parameter int NumW = 80,
  parameter int DenW = 50,
  parameter int QW = 29
) (
  input  wire logic            clk,
  input  wire logic            en,
  input  wire logic [NumW-1:0] num,
  input  wire logic [DenW-1:0] den,
  output logic [QW-1:0]        quo
);
  // Caller guarantees num < den * 2^QW.
  for (genvar s = 0; s < QW; s++) begin : g_st
    logic [DenW:0]   rem_r;
    logic [NumW-1:0] num_r;
    logic [DenW-1:0] den_r;
    logic [QW-1:0]   q_r;
    logic [DenW+1:0] trial;
    logic [DenW:0]   rem_nxt;
    logic [DenW:0]   top;
    logic [NumW-1:0] num_in;
    logic [DenW-1:0] den_in;
    logic [QW-1:0]   q_in;
    if (s == 0) begin : g_head
      assign num_in = num;
      assign den_in = den;
      assign q_in = '0;
      assign top = (DenW+1)'(num >> (QW - 1));
    end else begin : g_body
      assign num_in = g_st[s-1].num_r;
      assign den_in = g_st[s-1].den_r;
      assign q_in = g_st[s-1].q_r;
      assign top = {g_st[s-1].rem_r[DenW-1:0], g_st[s-1].num_r[QW-1-s]};
    end
    always_comb begin
      trial = {1'b0, top} - {2'b00, den_in};
      rem_nxt = trial[DenW+1] ? top : trial[DenW:0];
    end
    always_ff @(posedge clk) begin
      if (en) begin
        rem_r <= rem_nxt;
        num_r <= num_in;
        den_r <= den_in;
        q_r <= {q_in[QW-2:0], ~trial[DenW+1]};
      end
    end
  end

  assign quo = g_st[QW-1].q_r;
endmodule
`default_nettype wire

// File: hdl/world_to_screen_projection.sv
// Top level: matrix store, two transform stages, clip test, divider pipeline.
// Depends on w2s_pkg, w2s_xform, w2s_divider, world_to_screen_projection_defines.svh.
//
// Channel  Dir  Handshake              Payload
// in_      in   in_valid/in_ready      w2s_in_t
// out_     out  out_valid/out_ready    w2s_out_t
// cfg_     in   APB psel/penable       screen_width, screen_height
//
// Items pass the view and projection transforms, the clip and scale registers,
// 29 divider stages and the output register, one item per cycle whenever the
// output register is empty or taken; a stall freezes every stage. Reset sets
// identity matrices and a 1920x1080 viewport. Load items leave no result.
`default_nettype none
`include "world_to_screen_projection_defines.svh"
module world_to_screen_projection
  import w2s_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire w2s_in_t     in_data,
  output logic             out_valid,
  input  wire logic        out_ready,
  output w2s_out_t         out_data,
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [2:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic [31:0]      cfg_prdata,
  output logic             cfg_pready
);
  localparam int QW = 29;
  localparam int DepW = 17;

  logic en;
  logic [12:0] width_r, height_r;
  logic signed [31:0] view_r [16];
  logic signed [31:0] proj_r [16];

  assign cfg_pready = 1'b1;
  assign en = !out_valid || out_ready;
  assign in_ready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r <= 13'd1920;
      height_r <= 13'd1080;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_paddr[1:0] == 2'b00) begin
      if (cfg_paddr[2] == RegWidth) width_r <= cfg_pwdata[12:0];
      else height_r <= cfg_pwdata[12:0];
    end
  end
  assign cfg_prdata = {19'd0, (cfg_paddr[2] == RegWidth) ? width_r : height_r};

  // Projection writes pass two delay registers (ldp1_r, ldp2_r), so a point still in the view
  // stage keeps the projection matrix it was accepted with.
  logic load_acc;
  logic ldp1_r, ldp2_r;
  logic [3:0] ldi1_r, ldi2_r;
  logic signed [31:0] ldv1_r, ldv2_r;
  assign load_acc = in_valid && in_ready && in_data.kind == KindLoad;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 16; i++) begin
        view_r[i] <= (i % 5 == 0) ? OneQ16 : 32'sd0;
        proj_r[i] <= (i % 5 == 0) ? OneQ16 : 32'sd0;
      end
      ldp1_r <= 1'b0;
      ldp2_r <= 1'b0;
    end else begin
      if (load_acc && in_data.matrix_select == MatView)
        view_r[in_data.element_index] <= in_data.element_value;
      if (en) begin
        ldp1_r <= load_acc && in_data.matrix_select == MatProj;
        ldi1_r <= in_data.element_index;
        ldv1_r <= in_data.element_value;
        ldp2_r <= ldp1_r;
        ldi2_r <= ldi1_r;
        ldv2_r <= ldv1_r;
        if (ldp2_r) proj_r[ldi2_r] <= ldv2_r;
      end
    end
  end

  logic v0;
  logic signed [AccW-1:0] p_vec [4];
  assign v0 = in_valid && in_data.kind == KindProject;
  assign p_vec[0] = AccW'(in_data.pos_x);
  assign p_vec[1] = AccW'(in_data.pos_y);
  assign p_vec[2] = AccW'(in_data.pos_z);
  assign p_vec[3] = AccW'(OneQ16);

  logic v1, v2;
  logic signed [AccW-1:0] v_vec [4];
  logic signed [AccW-1:0] c_vec [4];
  w2s_xform u_view (.clk, .rst_n, .en, .v_in(v0), .vin(p_vec), .mat(view_r),
                    .v_out(v1), .vout(v_vec));
  w2s_xform u_proj (.clk, .rst_n, .en, .v_in(v1), .vin(v_vec), .mat(proj_r),
                    .v_out(v2), .vout(c_vec));

  // Clip test and numerator preparation.
  logic v3_r, on3_r;
  logic [AccW:0] sx3_r, sy3_r;
  logic [AccW-1:0] z3_r;
  logic [AccW:0] den3_r;
  logic [12:0] wd3_r, ht3_r;
  logic signed [AccW-1:0] x, y, z, w;
  logic on_nxt;
  assign x = c_vec[0];
  assign y = c_vec[1];
  assign z = c_vec[2];
  assign w = c_vec[3];
  assign on_nxt = (w > 0) && (x >= -w) && (x <= w) && (y >= -w) && (y <= w)
                  && (z >= 0) && (z <= w);
  always_ff @(posedge clk) begin
    if (!rst_n) v3_r <= 1'b0;
    else if (en) v3_r <= v2;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      on3_r <= on_nxt;
      sx3_r <= (AccW+1)'($signed({x[AccW-1], x}) + $signed({w[AccW-1], w}));
      sy3_r <= (AccW+1)'($signed({w[AccW-1], w}) - $signed({y[AccW-1], y}));
      z3_r <= z;
      den3_r <= {w, 1'b0};
      wd3_r <= width_r;
      ht3_r <= height_r;
    end
  end

  // Scale x and y by viewport size (one 49x13 multiply each), shift by 16.
  logic v4_r, on4_r;
  logic [79:0] nx4_r, ny4_r, nz4_r;
  logic [49:0] dx4_r, dz4_r;
  always_ff @(posedge clk) begin
    if (!rst_n) v4_r <= 1'b0;
    else if (en) v4_r <= v3_r;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      on4_r <= on3_r;
      nx4_r <= on3_r ? 80'(sx3_r) * 80'(wd3_r) << 16 : '0;
      ny4_r <= on3_r ? 80'(sy3_r) * 80'(ht3_r) << 16 : '0;
      nz4_r <= on3_r ? 80'(z3_r) << 16 : '0;
      dx4_r <= on3_r ? 50'(den3_r) : 50'd1;
      dz4_r <= on3_r ? 50'(den3_r >> 1) : 50'd1;
    end
  end

  logic [QW-1:0] qx, qy, qz;
  w2s_divider #(.NumW(80), .DenW(50), .QW(QW)) u_divx
    (.clk, .en, .num(nx4_r), .den(dx4_r), .quo(qx));
  w2s_divider #(.NumW(80), .DenW(50), .QW(QW)) u_divy
    (.clk, .en, .num(ny4_r), .den(dx4_r), .quo(qy));
  w2s_divider #(.NumW(80), .DenW(50), .QW(QW)) u_divz
    (.clk, .en, .num(nz4_r), .den(dz4_r), .quo(qz));

  logic [QW-1:0] vd_r;
  logic [QW-1:0] ond_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vd_r <= '0;
      out_valid <= 1'b0;
    end else if (en) begin
      vd_r <= {vd_r[QW-2:0], v4_r};
      out_valid <= vd_r[QW-1];
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      ond_r <= {ond_r[QW-2:0], on4_r};
      out_data.on_screen <= ond_r[QW-1];
      out_data.screen_x <= qx;
      out_data.screen_y <= qy;
      out_data.depth <= qz[DepW-1:0];
    end
  end

  `W2S_ASSERT_IMP(a_hold, clk, rst_n, out_valid && !out_ready, !in_ready)
  `W2S_ASSERT_NXT(a_keep, clk, rst_n, out_valid && !out_ready, out_valid)
  `W2S_ASSERT_IMP(a_off0, clk, rst_n, out_valid && !out_data.on_screen,
                  out_data.screen_x == '0 && out_data.depth == '0)
endmodule
`default_nettype wire
